[design/afbs_pkg.sv]
// Shared types and constants for the affine bitmap sampler.
`timescale 1ns / 1ps

package afbs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INV_A         = 3'd0,
    CFG_INV_B         = 3'd1,
    CFG_INV_C         = 3'd2,
    CFG_INV_D         = 3'd3,
    CFG_INV_TX        = 3'd4,
    CFG_INV_TY        = 3'd5,
    CFG_BITMAP_WIDTH  = 3'd6,
    CFG_BITMAP_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  localparam logic signed [31:0] InvOneQ16 = 32'sd65536;
  localparam logic [7:0]         DimReset  = 8'd128;

  // Product, sum and truncated coordinate widths of the mapping datapath.
  localparam int unsigned ProdW = 48;
  localparam int unsigned SumW  = 50;
  localparam int unsigned FracW = 16;
  localparam int unsigned TexW  = SumW - FracW;

  typedef struct packed {
    logic              op;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [7:0]        in_red;
    logic [7:0]        in_green;
    logic [7:0]        in_blue;
    logic [7:0]        in_alpha;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;
    logic [7:0]        out_alpha;
  } out_word_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } texel_t;

endpackage

[design/affine_bitmap_sampler.sv]
// Top level of the affine bitmap sampler: mapping pipeline, texel memory and output queue.
`timescale 1ns / 1ps

// The sampler takes one word per clock cycle, query or texel write, and keeps that rate
// for as long as the output side takes results. The four products of the inverse matrix
// are formed in the first stage, summed in the second, truncated toward zero in the third;
// the fourth stage makes the single access of the word to the single-port texel memory (a
// write for a texel word, a read for a query that falls inside the bitmap), and the fifth
// checks the read texel's alpha. Results wait in an eight-word output queue; the input
// stalls only when the queue and the words still in the pipeline could fill it. Texel
// memory has no reset and no clearing pass, so a texel must be written before a query
// samples it.
module affine_bitmap_sampler
  import afbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [AddrW-1:0] RowStride = AddrW'(MAX_WIDTH);
  localparam logic [TexW-2:0]  LimMaxW   = (TexW-1)'(MAX_WIDTH);
  localparam logic [TexW-2:0]  LimMaxH   = (TexW-1)'(MAX_HEIGHT);
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = 3;
  localparam int unsigned CntW      = 4;

  // Configuration registers.
  logic signed [31:0] inv_a_q, inv_b_q, inv_c_q, inv_d_q, inv_tx_q, inv_ty_q;
  logic [7:0]         bmp_w_q, bmp_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_a_q  <= InvOneQ16;
      inv_b_q  <= '0;
      inv_c_q  <= '0;
      inv_d_q  <= InvOneQ16;
      inv_tx_q <= '0;
      inv_ty_q <= '0;
      bmp_w_q  <= DimReset;
      bmp_h_q  <= DimReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INV_A:         inv_a_q  <= cfg_data_i;
        CFG_INV_B:         inv_b_q  <= cfg_data_i;
        CFG_INV_C:         inv_c_q  <= cfg_data_i;
        CFG_INV_D:         inv_d_q  <= cfg_data_i;
        CFG_INV_TX:        inv_tx_q <= cfg_data_i;
        CFG_INV_TY:        inv_ty_q <= cfg_data_i;
        CFG_BITMAP_WIDTH:  bmp_w_q  <= cfg_data_i[7:0];
        CFG_BITMAP_HEIGHT: bmp_h_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Output queue occupancy and pipeline fill decide the input stall.
  logic [CntW-1:0] fifo_cnt_q, fifo_cnt_d;
  logic            v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [CntW-1:0] occupancy;
  logic            in_acc;

  assign occupancy = fifo_cnt_q + CntW'(v1_q) + CntW'(v2_q) + CntW'(v3_q)
                   + CntW'(v4_q) + CntW'(v5_q);
  assign in_stall_o = (occupancy >= CntW'(FifoDepth));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Stage 1: products.
  in_word_t            w1_q, w2_q, w3_q, w4_q;
  logic signed [ProdW-1:0] p_ax_q, p_by_q, p_cx_q, p_dy_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w1_q   <= in_word_i;
      p_ax_q <= ProdW'(inv_a_q) * ProdW'(in_word_i.coord_x);
      p_by_q <= ProdW'(inv_b_q) * ProdW'(in_word_i.coord_y);
      p_cx_q <= ProdW'(inv_c_q) * ProdW'(in_word_i.coord_x);
      p_dy_q <= ProdW'(inv_d_q) * ProdW'(in_word_i.coord_y);
    end
  end

  // Stage 2: sums.
  logic signed [SumW-1:0] u_q, v_q;

  always_ff @(posedge clk_i) begin
    w2_q <= w1_q;
    u_q  <= SumW'(p_ax_q) + SumW'(p_by_q) + SumW'(inv_tx_q);
    v_q  <= SumW'(p_cx_q) + SumW'(p_dy_q) + SumW'(inv_ty_q);
  end

  // Stage 3: truncation toward zero; a texel word passes its column and row.
  logic signed [TexW-1:0] col_d, row_d, col_q, row_q;

  always_comb begin
    if (w2_q.op == OP_WRITE) begin
      col_d = TexW'(w2_q.coord_x);
      row_d = TexW'(w2_q.coord_y);
    end else begin
      col_d = u_q[SumW-1:FracW] + TexW'(u_q[SumW-1] && (u_q[FracW-1:0] != '0));
      row_d = v_q[SumW-1:FracW] + TexW'(v_q[SumW-1] && (v_q[FracW-1:0] != '0));
    end
  end

  always_ff @(posedge clk_i) begin
    w3_q  <= w2_q;
    col_q <= col_d;
    row_q <= row_d;
  end

  // Stage 4: bounds check and memory access.
  logic [TexW-2:0]  lim_w, lim_h;
  logic             in_box;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;
  texel_t           mem_wdata, rdata_q;
  texel_t           texel_mem [Depth];

  always_comb begin
    if (w3_q.op == OP_WRITE) begin
      lim_w = LimMaxW;
      lim_h = LimMaxH;
    end else begin
      lim_w = ((TexW-1)'(bmp_w_q) > LimMaxW) ? LimMaxW : (TexW-1)'(bmp_w_q);
      lim_h = ((TexW-1)'(bmp_h_q) > LimMaxH) ? LimMaxH : (TexW-1)'(bmp_h_q);
    end
  end

  assign in_box    = !col_q[TexW-1] && !row_q[TexW-1]
                   && (col_q[TexW-2:0] < lim_w) && (row_q[TexW-2:0] < lim_h);
  assign mem_we    = v3_q && in_box && (w3_q.op == OP_WRITE);
  assign mem_re    = v3_q && in_box && (w3_q.op == OP_QUERY);
  assign mem_addr  = AddrW'(row_q[RowW-1:0]) * RowStride + AddrW'(col_q[ColW-1:0]);
  assign mem_wdata = '{alpha: w3_q.in_alpha, blue: w3_q.in_blue,
                       green: w3_q.in_green, red: w3_q.in_red};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      texel_mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= texel_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    w4_q <= w3_q;
  end

  // Pipeline valids; stage 5 only tracks queries that read the memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= mem_re;
    end
  end

  // Stage 5: alpha test and output queue.
  out_word_t       fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic            push, pop;

  assign push = v5_q && (rdata_q.alpha != '0);
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{out_x: w4_q.coord_x, out_y: w4_q.coord_y,
                            out_red: rdata_q.red, out_green: rdata_q.green,
                            out_blue: rdata_q.blue, out_alpha: rdata_q.alpha};
    end
  end

  always_comb begin
    fifo_cnt_d = fifo_cnt_q;
    if (push && !pop) begin
      fifo_cnt_d = fifo_cnt_q + CntW'(1);
    end else if (pop && !push) begin
      fifo_cnt_d = fifo_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_word_o  = fifo_q[rd_ptr_q];

  // The queue never holds more words than it has entries.
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= CntW'(FifoDepth))
    else $error("output queue count exceeds its depth");

  // A result is pushed only where the queue has room for it.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < CntW'(FifoDepth)) || pop)
    else $error("result pushed into a full output queue");

  // The single memory port serves one access per cycle.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("texel memory written and read in the same cycle");

  // A query read comes from a word that was in the access stage in the cycle before.
  a_read_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> $past(v3_q) && ($past(w3_q.op) == OP_QUERY))
    else $error("texel read result without a query in the access stage");

  // Every word shown at the output carries a visible texel.
  a_alpha_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.out_alpha != '0))
    else $error("output word with zero alpha");

endmodule

[tb/sv/afbs_checker.sv]
// Checker for the affine bitmap sampler: mirrors the texel memory and registers, predicts pixels.
`timescale 1ns / 1ps

module afbs_checker
  import afbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_word_t            in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_word_t           out_word_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned MapW = 128;
  localparam int unsigned MapH = 128;

  logic signed [31:0] m_a, m_b, m_c, m_d, m_tx, m_ty;
  logic [7:0]         dim_w, dim_h;
  texel_t             texels [MapW*MapH];
  out_word_t          pending_pixels [$];
  int unsigned        fails;

  function automatic bit sample_pixel(input in_word_t q, output out_word_t px);
    longint x, y, col, row, lim_w, lim_h;
    texel_t t;
    x = longint'(q.coord_x);
    y = longint'(q.coord_y);
    col = (longint'(m_a) * x + longint'(m_b) * y + longint'(m_tx)) / longint'(65536);
    row = (longint'(m_c) * x + longint'(m_d) * y + longint'(m_ty)) / longint'(65536);
    lim_w = longint'(dim_w);
    lim_h = longint'(dim_h);
    if (lim_w > longint'(MapW)) lim_w = longint'(MapW);
    if (lim_h > longint'(MapH)) lim_h = longint'(MapH);
    if (col < 0 || col >= lim_w || row < 0 || row >= lim_h) return 1'b0;
    t = texels[row * MapW + col];
    if (t.alpha == 8'd0) return 1'b0;
    px.out_x     = q.coord_x;
    px.out_y     = q.coord_y;
    px.out_red   = t.red;
    px.out_green = t.green;
    px.out_blue  = t.blue;
    px.out_alpha = t.alpha;
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    out_word_t want, px;
    texel_t    t;
    longint    x, y;
    if (!rst_ni) begin
      m_a   = InvOneQ16;
      m_b   = '0;
      m_c   = '0;
      m_d   = InvOneQ16;
      m_tx  = '0;
      m_ty  = '0;
      dim_w = DimReset;
      dim_h = DimReset;
      fails = 0;
      pending_pixels.delete();
      for (int i = 0; i < MapW * MapH; i++) texels[i] = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel at x %0d y %0d", out_word_i.out_x, out_word_i.out_y);
          fails++;
        end else begin
          want = pending_pixels.pop_front();
          compare_field("out_x", want.out_x, out_word_i.out_x);
          compare_field("out_y", want.out_y, out_word_i.out_y);
          compare_field("out_red", 16'(want.out_red), 16'(out_word_i.out_red));
          compare_field("out_green", 16'(want.out_green), 16'(out_word_i.out_green));
          compare_field("out_blue", 16'(want.out_blue), 16'(out_word_i.out_blue));
          compare_field("out_alpha", 16'(want.out_alpha), 16'(out_word_i.out_alpha));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.op == OP_WRITE) begin
          x = longint'(in_word_i.coord_x);
          y = longint'(in_word_i.coord_y);
          if (x >= 0 && x < longint'(MapW) && y >= 0 && y < longint'(MapH)) begin
            t.red   = in_word_i.in_red;
            t.green = in_word_i.in_green;
            t.blue  = in_word_i.in_blue;
            t.alpha = in_word_i.in_alpha;
            texels[y * MapW + x] = t;
          end
        end else if (sample_pixel(in_word_i, px)) begin
          pending_pixels.push_back(px);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_INV_A:         m_a   = cfg_data_i;
          CFG_INV_B:         m_b   = cfg_data_i;
          CFG_INV_C:         m_c   = cfg_data_i;
          CFG_INV_D:         m_d   = cfg_data_i;
          CFG_INV_TX:        m_tx  = cfg_data_i;
          CFG_INV_TY:        m_ty  = cfg_data_i;
          CFG_BITMAP_WIDTH:  dim_w = cfg_data_i[7:0];
          CFG_BITMAP_HEIGHT: dim_h = cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_pixels.size();
  end

endmodule

[tb/sv/affine_bitmap_sampler_tb.sv]
// Testbench top for the affine bitmap sampler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module affine_bitmap_sampler_tb;
  import afbs_pkg::*;

  localparam int unsigned MapW = 128;
  localparam int unsigned MapH = 128;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_word;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         fail_count;
  int unsigned         pending;
  logic                hold_req;
  bit                  dense;
  int unsigned         burst_left;
  logic signed [31:0]  sh_a, sh_b, sh_c, sh_d, sh_tx, sh_ty;
  logic [7:0]          sh_w, sh_h;
  bit                  written [MapW*MapH];

  affine_bitmap_sampler i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  afbs_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin : receiver
    int unsigned mode, span, k;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_req && !held) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (300) @(posedge clk);
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= k[0];
        endcase
      end
    end
  end

  function automatic bit lands_in_bitmap(input logic signed [15:0] x, y,
                                         output int unsigned site);
    longint sx, sy, col, row, lim_w, lim_h;
    sx = longint'(x);
    sy = longint'(y);
    col = (longint'(sh_a) * sx + longint'(sh_b) * sy + longint'(sh_tx)) / longint'(65536);
    row = (longint'(sh_c) * sx + longint'(sh_d) * sy + longint'(sh_ty)) / longint'(65536);
    lim_w = longint'(sh_w);
    lim_h = longint'(sh_h);
    if (lim_w > longint'(MapW)) lim_w = longint'(MapW);
    if (lim_h > longint'(MapH)) lim_h = longint'(MapH);
    if (col < 0 || col >= lim_w || row < 0 || row >= lim_h) return 1'b0;
    site = 32'(row) * MapW + 32'(col);
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] pick_coord();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 16'sh7FFF;
    if (roll == 1) return 16'sh8000;
    if (roll < 5) return 16'($urandom);
    return 16'(int'($urandom_range(0, 300)) - 16);
  endfunction

  function automatic logic [7:0] pick_alpha();
    if ($urandom_range(0, 3) == 0) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (!dense && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic send_texel(input logic signed [15:0] x, y, input logic [7:0] r, g, b, a);
    in_word_t w;
    int cx, cy;
    w.op       = OP_WRITE;
    w.coord_x  = x;
    w.coord_y  = y;
    w.in_red   = r;
    w.in_green = g;
    w.in_blue  = b;
    w.in_alpha = a;
    cx = int'(x);
    cy = int'(y);
    if (cx >= 0 && cx < int'(MapW) && cy >= 0 && cy < int'(MapH))
      written[cy * MapW + cx] = 1'b1;
    send_word(w);
  endtask

  task automatic send_query(input logic signed [15:0] x, y);
    in_word_t q;
    int unsigned site;
    if (lands_in_bitmap(x, y, site) && !written[site])
      send_texel(16'(site % MapW), 16'(site / MapW), 8'($urandom), 8'($urandom),
                 8'($urandom), pick_alpha());
    q.op       = OP_QUERY;
    q.coord_x  = x;
    q.coord_y  = y;
    q.in_red   = 8'($urandom);
    q.in_green = 8'($urandom);
    q.in_blue  = 8'($urandom);
    q.in_alpha = 8'($urandom);
    send_word(q);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_matrix(input logic signed [31:0] a, b, c, d, tx, ty,
                             input logic [7:0] w, h);
    quiesce();
    write_reg(CFG_INV_A, a);
    write_reg(CFG_INV_B, b);
    write_reg(CFG_INV_C, c);
    write_reg(CFG_INV_D, d);
    write_reg(CFG_INV_TX, tx);
    write_reg(CFG_INV_TY, ty);
    write_reg(CFG_BITMAP_WIDTH, {24'($urandom), w});
    write_reg(CFG_BITMAP_HEIGHT, {24'($urandom), h});
    cfg_we <= 1'b0;
    sh_a  = a;
    sh_b  = b;
    sh_c  = c;
    sh_d  = d;
    sh_tx = tx;
    sh_ty = ty;
    sh_w  = w;
    sh_h  = h;
  endtask

  task automatic run_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6)
        send_query(pick_coord(), pick_coord());
      else if ($urandom_range(0, 6) != 0)
        send_texel(16'($urandom_range(0, MapW - 1)), 16'($urandom_range(0, MapH - 1)),
                   8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
      else
        send_texel(pick_coord(), pick_coord(), 8'($urandom), 8'($urandom), 8'($urandom),
                   pick_alpha());
    end
  endtask

  function automatic logic signed [31:0] small_gain();
    int g;
    g = $urandom_range(16384, 131072);
    return ($urandom_range(0, 1) != 0) ? 32'(g) : 32'(-g);
  endfunction

  initial begin : stimulus
    int unsigned phase;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    hold_req <= 1'b0;
    dense      = 1'b0;
    burst_left = 0;
    sh_a  = InvOneQ16;
    sh_b  = '0;
    sh_c  = '0;
    sh_d  = InvOneQ16;
    sh_tx = '0;
    sh_ty = '0;
    sh_w  = DimReset;
    sh_h  = DimReset;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_texel(16'sd0, 16'sd0, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_texel(16'sd127, 16'sd127, 8'hFF, 8'hFF, 8'hFF, 8'h01);
    send_texel(16'sd5, 16'sd3, 8'hA5, 8'h5A, 8'hC3, 8'h00);
    send_texel(-16'sd1, 16'sd0, 8'h11, 8'h11, 8'h11, 8'h11);
    send_texel(16'sd128, 16'sd5, 8'h22, 8'h22, 8'h22, 8'h22);
    send_texel(16'sh7FFF, 16'sh8000, 8'h33, 8'h33, 8'h33, 8'h33);
    send_texel(16'sd127, 16'sd0, 8'h12, 8'h34, 8'h56, 8'h80);
    send_texel(16'sd0, 16'sd127, 8'hFF, 8'h00, 8'hFF, 8'h7F);
    send_query(16'sd0, 16'sd0);
    send_query(16'sd127, 16'sd127);
    send_query(16'sd5, 16'sd3);
    send_query(-16'sd1, 16'sd0);
    send_query(16'sd128, 16'sd0);
    send_query(16'sd0, 16'sd128);
    send_query(16'sh8000, 16'sh8000);
    send_query(16'sh7FFF, 16'sh7FFF);
    send_query(16'sd127, 16'sd0);
    send_query(16'sd0, 16'sd127);
    send_texel(16'sd0, 16'sd0, 8'h11, 8'h22, 8'h33, 8'h44);
    send_query(16'sd0, 16'sd0);
    // A half-texel negative offset must truncate toward zero, not round down.
    load_matrix(InvOneQ16, '0, '0, InvOneQ16, -32'sd32768, -32'sd32768, DimReset, DimReset);
    send_query(16'sd0, 16'sd0);
    send_query(16'sd128, 16'sd128);
    send_query(-16'sd1, -16'sd1);

    // Fill a corner, then let the output side hold off while queries keep coming.
    load_matrix(InvOneQ16, '0, '0, InvOneQ16, '0, '0, DimReset, DimReset);
    for (int yy = 0; yy < 8; yy++)
      for (int xx = 0; xx < 8; xx++)
        send_texel(16'(xx), 16'(yy), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom_range(1, 255)));
    quiesce();
    dense = 1'b1;
    hold_req <= 1'b1;
    for (int i = 0; i < 64; i++)
      send_query(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)));
    dense = 1'b0;

    for (phase = 0; phase < 11; phase++) begin
      case (phase)
        0: load_matrix(InvOneQ16, '0, '0, InvOneQ16, '0, '0, DimReset, DimReset);
        1: load_matrix(32'sd32768, '0, '0, 32'sd32768,
                       32'(int'($urandom_range(0, 131071)) - 65536),
                       32'(int'($urandom_range(0, 131071)) - 65536),
                       8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
        2: load_matrix(InvOneQ16, '0, '0, InvOneQ16, '0, '0, 8'd0, DimReset);
        3: load_matrix(InvOneQ16, '0, '0, InvOneQ16,
                       32'(-int'($urandom_range(1, 65535))),
                       32'(-int'($urandom_range(1, 65535))), 8'd255, 8'd200);
        4: load_matrix(-InvOneQ16, '0, '0, -InvOneQ16,
                       32'((127 << 16) + int'($urandom_range(0, 65535))),
                       32'((127 << 16) + int'($urandom_range(0, 65535))),
                       DimReset, DimReset);
        5: load_matrix(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                       32'sh7FFFFFFF, 32'sh80000000, 8'd1, 8'd1);
        9: load_matrix(32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                       32'($urandom), 32'($urandom),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        10: load_matrix(InvOneQ16, '0, '0, InvOneQ16, '0, '0, DimReset, 8'd0);
        default: load_matrix(small_gain(),
                             32'(int'($urandom_range(0, 65536)) - 32768),
                             32'(int'($urandom_range(0, 65536)) - 32768),
                             small_gain(),
                             32'(int'($urandom_range(0, 160 << 16)) - (16 << 16)),
                             32'(int'($urandom_range(0, 160 << 16)) - (16 << 16)),
                             8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
      endcase
      if (phase == 2 || phase == 5 || phase == 9 || phase == 10)
        run_random(80);
      else
        run_random(200);
    end

    quiesce();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
